@@ src/nmea_checksum_time_extract_macros.svh @@
// assertion helpers for the nmea checksum block
// clk and arst_n are taken from the module that uses them
`ifndef NMEA_CHECKSUM_TIME_EXTRACT_MACROS_SVH
`define NMEA_CHECKSUM_TIME_EXTRACT_MACROS_SVH

`ifndef SYNTHESIS

`define NCT_ASSERT_IMPL(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

`define NCT_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`else

`define NCT_ASSERT_IMPL(label, cond, prop, msg)

`define NCT_ASSERT_NEXT(label, cond, prop, msg)

`endif

`endif

@@ src/nct_pkg.sv @@
package nct_pkg;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_F   = 8'h46;
	localparam logic [7:0] CH_LO_A   = 8'h61;
	localparam logic [7:0] CH_LO_F   = 8'h66;

	localparam logic [3:0] TIME_FIRST_POS = 4'd7;
	localparam logic [3:0] TIME_LAST_POS  = 4'd12;
	localparam logic [3:0] POS_MAX        = 4'd15;

	localparam logic [6:0] HOURS_PER_DAY  = 7'd24;
	localparam logic [6:0] MAX_MIN_SEC    = 7'd59;
	localparam logic [4:0] HOUR_OFFSET_RST = 5'd8;

	localparam int NCT_QUEUE_DEPTH = 4;

	typedef logic [3:0] digit_t;

	// one finished sentence, handed from the parser to the result stage
	typedef struct packed {
		logic [7:0]       computed_sum;
		logic [7:0]       received_sum;
		digit_t [5:0]     time_digits;
		logic             bad_time;
	} nct_rec_t;

	typedef struct packed {
		logic             digit_error;
		logic [5:0]       second_out;
		logic [5:0]       minute_out;
		logic [4:0]       local_hour;
		logic [7:0]       received_sum;
		logic [7:0]       computed_sum;
		logic             checksum_ok;
	} nct_res_t;

	typedef struct packed {
		logic empty;
		logic full;
	} nct_qstat_t;

	// bit 4 set when the byte is not a hex digit
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] v;
		v = 5'h10;
		if (c >= CH_ZERO && c <= CH_NINE)
			v = {1'b0, 4'(c - CH_ZERO)};
		else if (c >= CH_UP_A && c <= CH_UP_F)
			v = {1'b0, 4'(c - CH_UP_A + 8'd10)};
		else if (c >= CH_LO_A && c <= CH_LO_F)
			v = {1'b0, 4'(c - CH_LO_A + 8'd10)};
		return v;
	endfunction

	// two decimal digits to a value, tens first
	function automatic logic [6:0] two_digits(input digit_t tens, input digit_t ones);
		return ({3'b000, tens} << 3) + ({3'b000, tens} << 1) + {3'b000, ones};
	endfunction

endpackage

@@ src/nct_front.sv @@
module nct_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,
	input  nct_pkg::nct_qstat_t q_stat,
	output logic                push,
	output nct_pkg::nct_rec_t   push_rec
);
	import nct_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_BODY = 4'b0010,
		ST_HEX1 = 4'b0100,
		ST_HEX2 = 4'b1000
	} state_t;

	state_t         state_q, state_d;
	logic [3:0]     pos_q;
	logic [7:0]     xor_q;
	digit_t         nib_q;
	digit_t [5:0]   digits_q;
	logic           bad_q;

	logic           accept;
	logic           is_dollar;
	logic           is_star;
	logic           is_digit;
	logic [4:0]     hexv;
	logic           hex_ok;
	logic           in_time;
	logic [2:0]     slot;

	assign s_tready  = !q_stat.full;
	assign accept    = s_tvalid && s_tready;
	assign is_dollar = (s_tdata == CH_DOLLAR);
	assign is_star   = (s_tdata == CH_STAR);
	assign is_digit  = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
	assign hexv      = hex_value(s_tdata);
	assign hex_ok    = !hexv[4];
	assign in_time   = (pos_q >= TIME_FIRST_POS) && (pos_q <= TIME_LAST_POS);
	assign slot      = 3'(pos_q - TIME_FIRST_POS);

	always_comb begin
		state_d = state_q;
		if (accept) begin
			if (is_dollar) begin
				state_d = ST_BODY;
			end else begin
				unique case (state_q)
					ST_IDLE: state_d = ST_IDLE;
					ST_BODY: state_d = is_star ? ST_HEX1 : ST_BODY;
					ST_HEX1: state_d = hex_ok ? ST_HEX2 : ST_IDLE;
					ST_HEX2: state_d = ST_IDLE;
					default: state_d = ST_IDLE;
				endcase
			end
		end
	end

	// second hex digit closes the sentence
	assign push = accept && !is_dollar && (state_q == ST_HEX2) && hex_ok;

	always_comb begin
		push_rec.computed_sum = xor_q;
		push_rec.received_sum = {nib_q, hexv[3:0]};
		push_rec.time_digits  = digits_q;
		// a short sentence leaves time characters missing
		push_rec.bad_time     = bad_q || (pos_q <= TIME_LAST_POS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
			xor_q   <= '0;
			nib_q   <= '0;
			bad_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (is_dollar) begin
					pos_q <= 4'd1;
					xor_q <= '0;
					nib_q <= '0;
					bad_q <= 1'b0;
				end else if (state_q == ST_BODY && !is_star) begin
					xor_q <= xor_q ^ s_tdata;
					if (in_time && !is_digit)
						bad_q <= 1'b1;
					if (pos_q != POS_MAX)
						pos_q <= pos_q + 4'd1;
				end else if (state_q == ST_HEX1 && hex_ok) begin
					nib_q <= hexv[3:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (is_dollar) begin
				digits_q <= '0;
			end else if (state_q == ST_BODY && !is_star && in_time) begin
				digits_q[slot] <= is_digit ? 4'(s_tdata - CH_ZERO) : 4'd0;
			end
		end
	end

endmodule

@@ src/nct_queue.sv @@
module nct_queue #(
	parameter int DEPTH = nct_pkg::NCT_QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  nct_pkg::nct_rec_t   push_rec,
	input  logic                pop,
	output nct_pkg::nct_rec_t   head,
	output nct_pkg::nct_qstat_t q_stat
);
	import nct_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	nct_rec_t          mem_q [DEPTH];
	logic [AW-1:0]     wr_ptr_q;
	logic [AW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;
	logic              do_push;
	logic              do_pop;

	function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign q_stat.empty = (count_q == '0);
	assign q_stat.full  = (count_q == CW'(DEPTH));
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_rec;
	end

endmodule

@@ src/nct_back.sv @@
module nct_back (
	input  logic                clk,
	input  logic                arst_n,
	input  nct_pkg::nct_rec_t   head,
	input  nct_pkg::nct_qstat_t q_stat,
	output logic                pop,
	input  logic [4:0]          hour_offset,
	output logic                m_tvalid,
	input  logic                m_tready,
	output nct_pkg::nct_res_t   res
);
	import nct_pkg::*;

	logic [6:0]  hour;
	logic [6:0]  minute;
	logic [6:0]  second;
	logic        err;
	logic [7:0]  hsum;
	logic [7:0]  hwrap;
	nct_res_t    res_d;
	nct_res_t    res_q;
	logic        m_tvalid_q;

	assign hour   = two_digits(head.time_digits[0], head.time_digits[1]);
	assign minute = two_digits(head.time_digits[2], head.time_digits[3]);
	assign second = two_digits(head.time_digits[4], head.time_digits[5]);

	assign err = head.bad_time || (hour >= HOURS_PER_DAY) ||
		(minute > MAX_MIN_SEC) || (second > MAX_MIN_SEC);

	// offset is sign extended; the extra day keeps the sum positive
	assign hsum = {1'b0, hour} + {1'b0, HOURS_PER_DAY} + {{3{hour_offset[4]}}, hour_offset};

	// with a valid hour the sum stays below three days
	always_comb begin
		if (hsum >= {HOURS_PER_DAY, 1'b0})
			hwrap = hsum - {HOURS_PER_DAY, 1'b0};
		else if (hsum >= {1'b0, HOURS_PER_DAY})
			hwrap = hsum - {1'b0, HOURS_PER_DAY};
		else
			hwrap = hsum;
	end

	always_comb begin
		res_d.checksum_ok  = (head.computed_sum == head.received_sum);
		res_d.computed_sum = head.computed_sum;
		res_d.received_sum = head.received_sum;
		res_d.local_hour   = err ? 5'd0 : hwrap[4:0];
		res_d.minute_out   = err ? 6'd0 : minute[5:0];
		res_d.second_out   = err ? 6'd0 : second[5:0];
		res_d.digit_error  = err;
	end

	assign pop      = !q_stat.empty && (!m_tvalid_q || m_tready);
	assign m_tvalid = m_tvalid_q;
	assign res      = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (pop) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			res_q <= res_d;
	end

endmodule

@@ src/nmea_checksum_time_extract.sv @@
// nmea sentence checksum check with local time extraction
// s_tdata carries one received byte per request; s_tready stays high unless the
// internal queue of finished sentences is full, so one byte per cycle is taken
// m_tdata carries one result per sentence, raised by the second hex digit
// after the star; the edge that takes that byte writes the queue, and m_tvalid
// rises when the result moves into the output register, which waits while full
// throughput is one byte per cycle on the input and one result per cycle on
// the output while m_tready is high, set by the single parse stage and the
// single result stage; cfg_wr_en / cfg_wr_data write the signed hour offset,
// only while idle (a user rule, unenforced); reset clears the parser to outside
// a sentence, empties the queue, drops m_tvalid and sets the hour offset to
// eight; a stalled receiver holds the result in the output register; up to
// QUEUE_DEPTH further sentences are buffered before s_tready drops, and bytes
// that close no sentence are only held back once the queue is full
`include "nmea_checksum_time_extract_macros.svh"

module nmea_checksum_time_extract #(
	parameter int QUEUE_DEPTH = nct_pkg::NCT_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,     // char_in
	output logic        m_tvalid,
	input  logic        m_tready,
	// checksum_ok, computed_sum, received_sum, local_hour, minute_out,
	// second_out, digit_error, zero fill
	output logic [39:0] m_tdata,
	input  logic        cfg_wr_en,
	input  logic [4:0]  cfg_wr_data  // hour_offset
);
	import nct_pkg::*;

	logic        push;
	nct_rec_t    push_rec;
	nct_rec_t    head;
	nct_qstat_t  q_stat;
	logic        pop;
	nct_res_t    res;
	logic [4:0]  hour_offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hour_offset_q <= HOUR_OFFSET_RST;
		end else if (cfg_wr_en) begin
			hour_offset_q <= cfg_wr_data;
		end
	end

	nct_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_stat   (q_stat),
		.push     (push),
		.push_rec (push_rec)
	);

	nct_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	nct_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_stat      (q_stat),
		.pop         (pop),
		.hour_offset (hour_offset_q),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.res         (res)
	);

	assign m_tdata = {5'b00000, res};

	`NCT_ASSERT_IMPL(a_err_zero_time, m_tvalid && res.digit_error,
		res.local_hour == 5'd0 && res.minute_out == 6'd0 && res.second_out == 6'd0,
		"time fields not cleared on digit error")

	`NCT_ASSERT_IMPL(a_time_range, m_tvalid && !res.digit_error,
		res.local_hour < 5'd24 && res.minute_out < 6'd60 && res.second_out < 6'd60,
		"time field out of range without digit error")

	`NCT_ASSERT_IMPL(a_sum_match, m_tvalid,
		res.checksum_ok == (res.computed_sum == res.received_sum),
		"checksum flag disagrees with the sums")

	`NCT_ASSERT_NEXT(a_queue_drain, !q_stat.empty && (!m_tvalid || m_tready),
		m_tvalid,
		"queued sentence not moved to the output register")

endmodule

@@ sim/tb.sv @@
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import nct_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_BYTES = 200;

	typedef enum logic [1:0] {PH_BODY, PH_HEX_HI, PH_HEX_LO} parse_phase_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;     // char_in
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// checksum_ok, computed_sum, received_sum, local_hour, minute_out,
	// second_out, digit_error, zero fill
	logic [39:0] m_tdata;
	logic        cfg_wr_en = 1'b0;
	logic [4:0]  cfg_wr_data = 5'd0;  // hour_offset

	nmea_checksum_time_extract i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// sentence tracker, mirrors the parser
	logic              in_sent = 1'b0;
	parse_phase_t      phase_q = PH_BODY;
	logic [3:0]        pos_q = 4'd0;
	logic [7:0]        xor_q = 8'h00;
	logic [3:0]        hi_nib = 4'h0;
	logic [3:0]        time_dig [6] = '{default: 4'h0};
	logic              time_bad = 1'b0;
	logic signed [4:0] hour_ofs = 5'sd8;

	nct_res_t   sentence_q [$];
	logic [7:0] frame [$];

	int  used_bytes = 0;
	int  n_results = 0;
	int  n_errors = 0;
	int  n_cfg = 0;
	int  cycles = 0;
	int  hold_req = 0;
	int  hold_left = 0;
	int  rx_gap = 0;
	bit  tx_idle = 1'b1;
	bit  rx_idle = 1'b1;

	// mostly short gaps, now and then a long one
	function automatic int pick_gap(input bit on);
		int r;
		if (!on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 2);
		if (r < 97)
			return $urandom_range(3, 8);
		return $urandom_range(15, 40);
	endfunction

	// bit 4 flags a byte that is no hex digit
	function automatic logic [4:0] nibble_of(input logic [7:0] c);
		if (c >= CH_ZERO && c <= CH_NINE)
			return {1'b0, 4'(c - CH_ZERO)};
		if (c >= CH_UP_A && c <= CH_UP_F)
			return {1'b0, 4'(c - CH_UP_A + 8'd10)};
		if (c >= CH_LO_A && c <= CH_LO_F)
			return {1'b0, 4'(c - CH_LO_A + 8'd10)};
		return 5'h10;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
		if (n < 4'd10)
			return CH_ZERO + 8'(n);
		return (lower ? CH_LO_A : CH_UP_A) + 8'(n) - 8'd10;
	endfunction

	// any byte that neither opens nor closes a sentence
	function automatic logic [7:0] body_byte();
		logic [7:0] b;
		do begin
			if ($urandom_range(0, 3) == 0)
				b = 8'($urandom_range(0, 255));
			else
				b = 8'($urandom_range(32, 126));
		end while (b == CH_DOLLAR || b == CH_STAR);
		return b;
	endfunction

	function automatic logic [7:0] non_hex_byte();
		logic [7:0] b;
		logic [4:0] v;
		do begin
			b = 8'($urandom_range(0, 255));
			v = nibble_of(b);
		end while (!v[4] || b == CH_DOLLAR);
		return b;
	endfunction

	// update the tracker with one taken byte, queue a result when one is due
	task automatic take_byte(input logic [7:0] c);
		logic [4:0] v;
		int         hr, mn, sc, lh;
		logic       err;
		nct_res_t   r;
		if (c == CH_DOLLAR || in_sent)
			used_bytes++;
		if (c == CH_DOLLAR) begin
			in_sent = 1'b1;
			phase_q = PH_BODY;
			pos_q = 4'd1;
			xor_q = 8'h00;
			hi_nib = 4'h0;
			foreach (time_dig[k])
				time_dig[k] = 4'h0;
			time_bad = 1'b0;
			return;
		end
		if (!in_sent)
			return;
		if (phase_q == PH_BODY) begin
			if (c == CH_STAR) begin
				phase_q = PH_HEX_HI;
				return;
			end
			xor_q ^= c;
			if (pos_q >= TIME_FIRST_POS && pos_q <= TIME_LAST_POS) begin
				if (c >= CH_ZERO && c <= CH_NINE)
					time_dig[pos_q - TIME_FIRST_POS] = 4'(c - CH_ZERO);
				else begin
					time_dig[pos_q - TIME_FIRST_POS] = 4'h0;
					time_bad = 1'b1;
				end
			end
			if (pos_q < POS_MAX)
				pos_q++;
			return;
		end
		v = nibble_of(c);
		if (v[4]) begin
			in_sent = 1'b0;
			phase_q = PH_BODY;
			return;
		end
		if (phase_q == PH_HEX_HI) begin
			hi_nib = v[3:0];
			phase_q = PH_HEX_LO;
			return;
		end
		in_sent = 1'b0;
		phase_q = PH_BODY;
		hr = int'(time_dig[0]) * 10 + int'(time_dig[1]);
		mn = int'(time_dig[2]) * 10 + int'(time_dig[3]);
		sc = int'(time_dig[4]) * 10 + int'(time_dig[5]);
		err = time_bad || pos_q <= TIME_LAST_POS || hr >= int'(HOURS_PER_DAY) ||
			mn > int'(MAX_MIN_SEC) || sc > int'(MAX_MIN_SEC);
		lh = (hr + int'(HOURS_PER_DAY) + int'(hour_ofs)) % int'(HOURS_PER_DAY);
		r.computed_sum = xor_q;
		r.received_sum = {hi_nib, v[3:0]};
		r.checksum_ok  = (xor_q == {hi_nib, v[3:0]});
		r.local_hour   = err ? 5'd0 : 5'(lh);
		r.minute_out   = err ? 6'd0 : 6'(mn);
		r.second_out   = err ? 6'd0 : 6'(sc);
		r.digit_error  = err;
		sentence_q.push_back(r);
	endtask

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap(tx_idle);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		take_byte(b);
	endtask

	task automatic send_frame(input int count);
		for (int k = 0; k < count; k++)
			send_byte(frame[k]);
	endtask

	task automatic load_text(input string s);
		frame.delete();
		for (int k = 0; k < s.len(); k++)
			frame.push_back(s[k]);
	endtask

	// close the frame with the star and the checksum, wrong on request
	task automatic append_sum(input bit corrupt);
		logic [7:0] s;
		s = 8'h00;
		for (int k = 1; k < frame.size(); k++)
			s ^= frame[k];
		if (corrupt)
			s ^= 8'($urandom_range(1, 255));
		frame.push_back(CH_STAR);
		frame.push_back(hex_char(s[7:4], $urandom_range(0, 1)));
		frame.push_back(hex_char(s[3:0], $urandom_range(0, 1)));
	endtask

	// stop offering, wait for every result, then let the pipeline settle
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sentence_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_offset(input logic [4:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		hour_ofs = v;
		n_cfg++;
	endtask

	task automatic random_sentence();
		int         kind, n, hr, mn, sc, idx, k;
		logic [7:0] b;
		kind = $urandom_range(0, 99);
		frame.delete();
		if (kind >= 96) begin
			// stray bytes, ignored unless a sentence is still open
			n = $urandom_range(1, 4);
			repeat (n) begin
				do
					b = 8'($urandom_range(0, 255));
				while (b == CH_DOLLAR);
				frame.push_back(b);
			end
			send_frame(frame.size());
			return;
		end
		frame.push_back(CH_DOLLAR);
		if (kind >= 77 && kind < 84) begin
			// star comes before the time field is complete
			n = $urandom_range(0, 11);
			repeat (n)
				frame.push_back(body_byte());
		end else begin
			repeat (5)
				frame.push_back(8'($urandom_range(CH_UP_A, 8'h5A)));
			frame.push_back(8'h2C);
			hr = $urandom_range(0, 23);
			mn = $urandom_range(0, 59);
			sc = $urandom_range(0, 59);
			if (kind >= 63 && kind < 70) begin
				case ($urandom_range(0, 2))
					0: hr = $urandom_range(24, 99);
					1: mn = $urandom_range(60, 99);
					default: sc = $urandom_range(60, 99);
				endcase
			end
			frame.push_back(CH_ZERO + 8'(hr / 10));
			frame.push_back(CH_ZERO + 8'(hr % 10));
			frame.push_back(CH_ZERO + 8'(mn / 10));
			frame.push_back(CH_ZERO + 8'(mn % 10));
			frame.push_back(CH_ZERO + 8'(sc / 10));
			frame.push_back(CH_ZERO + 8'(sc % 10));
			if (kind >= 70 && kind < 77) begin
				idx = $urandom_range(0, 5);
				do
					b = body_byte();
				while (b >= CH_ZERO && b <= CH_NINE);
				frame[7 + idx] = b;
			end
			n = $urandom_range(0, 8);
			repeat (n)
				frame.push_back(body_byte());
		end
		append_sum(kind >= 55 && kind < 63);
		if (kind >= 92) begin
			// broken hex digit, first or second
			k = frame.size() - $urandom_range(1, 2);
			frame[k] = non_hex_byte();
		end
		if (kind >= 84 && kind < 92)
			send_frame($urandom_range(1, frame.size() - 1));
		else
			send_frame(frame.size());
	endtask

	task automatic test_ignored_bytes();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(CH_STAR);
		wait_drained();
	endtask

	task automatic test_full_sentence();
		load_text("$GPZDA,235959");
		append_sum(1'b0);
		send_frame(frame.size());
		wait_drained();
	endtask

	// restarts in both hex digits, an abandoned checksum, then a short sentence
	task automatic test_restart_and_abandon();
		load_text("$A*$*0$*G$*00");
		send_frame(frame.size());
		wait_drained();
	endtask

	task automatic test_backpressure();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		hold_req = HOLD_CYCLES;
		repeat (12) begin
			frame.delete();
			frame.push_back(CH_DOLLAR);
			frame.push_back(body_byte());
			append_sum(1'b0);
			send_frame(frame.size());
		end
		wait_drained();
	endtask

	task automatic test_random_offsets();
		logic [4:0] ofs_list [7];
		int         target;
		ofs_list = '{5'b10100, 5'b01110, 5'b10000, 5'b01111, 5'b00000, 5'b11111,
			5'($urandom_range(0, 31))};
		for (int p = 0; p < 7; p++) begin
			wait_drained();
			write_offset(ofs_list[p]);
			tx_idle = (p % 4 == 0) || (p % 4 == 2);
			rx_idle = (p % 4 == 0) || (p % 4 == 3);
			target = used_bytes + PHASE_BYTES;
			while (used_bytes < target)
				random_sentence();
		end
		wait_drained();
	endtask

	// receiver side: random stalls, plus one long hold on request
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			rx_gap = pick_gap(rx_idle);
		end
	end

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			n_errors++;
		end
	endtask

	always @(posedge clk) begin
		nct_res_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[34:0];
			if (sentence_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
				n_errors++;
			end else begin
				want = sentence_q.pop_front();
				n_results++;
				check_field("checksum_ok", want.checksum_ok, got.checksum_ok);
				check_field("computed_sum", want.computed_sum, got.computed_sum);
				check_field("received_sum", want.received_sum, got.received_sum);
				check_field("local_hour", want.local_hour, got.local_hour);
				check_field("minute_out", want.minute_out, got.minute_out);
				check_field("second_out", want.second_out, got.second_out);
				check_field("digit_error", want.digit_error, got.digit_error);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				sentence_q.size());
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_ignored_bytes();
		test_full_sentence();
		test_restart_and_abandon();
		test_backpressure();
		test_random_offsets();
		$display("%0d sentence bytes sent, %0d results checked, %0d offset writes",
			used_bytes, n_results, n_cfg);
		$display("restarts, bad checksums, bad and short time fields, long output hold");
		if (n_errors == 0 && sentence_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
